/* sv/hcb_pkg.sv */
// Shared types and codes for the Huffman code builder.
// Holds controller command codes, datapath status struct and result codes.
package hcb_pkg;

  localparam int CMD_W = 5;
  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t C_NOP      = 5'd0;
  localparam cmd_t C_LOAD     = 5'd1;
  localparam cmd_t C_QCAP     = 5'd2;
  localparam cmd_t C_BINIT    = 5'd3;
  localparam cmd_t C_CLR_RD   = 5'd4;
  localparam cmd_t C_CLR_WR   = 5'd5;
  localparam cmd_t C_RND_INIT = 5'd6;
  localparam cmd_t C_SCAN     = 5'd7;
  localparam cmd_t C_MW0      = 5'd8;
  localparam cmd_t C_MW1      = 5'd9;
  localparam cmd_t C_MW2      = 5'd10;
  localparam cmd_t C_WK_INIT  = 5'd11;
  localparam cmd_t C_WK_RD    = 5'd12;
  localparam cmd_t C_WK_L     = 5'd13;
  localparam cmd_t C_WK_R     = 5'd14;
  localparam cmd_t C_QRY_RD   = 5'd15;
  localparam cmd_t C_OUT_B    = 5'd16;
  localparam cmd_t C_OUT_Q    = 5'd17;

  typedef struct packed {
    logic idx_last;
    logic m_lt2;
    logic scan_last;
    logic round_last;
    logic k_zero;
    logic out_busy;
  } dp_stat_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FEW       = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_CODE  = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int CODE_W  = 64;
  localparam int DEPTH_W = 7;

endpackage

/* sv/hcb_ctrl.sv */
// Sequencer for the Huffman code builder: load, clear, merge, walk, query.
// Depends on hcb_pkg for command codes and the datapath status struct.
module hcb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             in_op,
  input  logic             in_last,
  input  hcb_pkg::dp_stat_t stat,
  output logic             idle,
  output hcb_pkg::cmd_t    cmd
);
  import hcb_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_BINIT = 5'd1;
  localparam logic [4:0] S_CRD   = 5'd2;
  localparam logic [4:0] S_CWR   = 5'd3;
  localparam logic [4:0] S_MINIT = 5'd4;
  localparam logic [4:0] S_SCAN  = 5'd5;
  localparam logic [4:0] S_SEND  = 5'd6;
  localparam logic [4:0] S_MW0   = 5'd7;
  localparam logic [4:0] S_MW1   = 5'd8;
  localparam logic [4:0] S_MW2   = 5'd9;
  localparam logic [4:0] S_WINIT = 5'd10;
  localparam logic [4:0] S_WRD   = 5'd11;
  localparam logic [4:0] S_WL    = 5'd12;
  localparam logic [4:0] S_WR    = 5'd13;
  localparam logic [4:0] S_QRD   = 5'd14;
  localparam logic [4:0] S_OUTB  = 5'd15;
  localparam logic [4:0] S_OUTQ  = 5'd16;

  logic [4:0] state_r, state_nxt;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = C_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_QUERY) begin
            cmd       = C_QCAP;
            state_nxt = S_QRD;
          end else begin
            cmd = C_LOAD;
            if (in_last) state_nxt = S_BINIT;
          end
        end
      end
      S_BINIT: begin
        cmd       = C_BINIT;
        state_nxt = S_CRD;
      end
      S_CRD: begin
        cmd       = C_CLR_RD;
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cmd       = C_CLR_WR;
        state_nxt = stat.idx_last ? S_MINIT : S_CRD;
      end
      S_MINIT: begin
        if (stat.m_lt2) begin
          state_nxt = S_OUTB;
        end else begin
          cmd       = C_RND_INIT;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd = C_SCAN;
        if (stat.scan_last) state_nxt = S_SEND;
      end
      // let the last read land in the compare stage
      S_SEND:  state_nxt = S_MW0;
      S_MW0: begin
        cmd       = C_MW0;
        state_nxt = S_MW1;
      end
      S_MW1: begin
        cmd       = C_MW1;
        state_nxt = S_MW2;
      end
      S_MW2: begin
        cmd       = C_MW2;
        state_nxt = stat.round_last ? S_WINIT : S_SCAN;
      end
      S_WINIT: begin
        cmd       = C_WK_INIT;
        state_nxt = S_WRD;
      end
      S_WRD: begin
        cmd       = C_WK_RD;
        state_nxt = S_WL;
      end
      S_WL: begin
        cmd       = C_WK_L;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd       = C_WK_R;
        state_nxt = stat.k_zero ? S_OUTB : S_WRD;
      end
      S_QRD: begin
        cmd       = C_QRY_RD;
        state_nxt = S_OUTQ;
      end
      S_OUTB: begin
        if (!stat.out_busy) begin
          cmd       = C_OUT_B;
          state_nxt = S_IDLE;
        end
      end
      S_OUTQ: begin
        if (!stat.out_busy) begin
          cmd       = C_OUT_Q;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* sv/hcb_dp.sv */
// Datapath of the Huffman code builder: node memories, scan compare, tree walk.
// Depends on hcb_pkg; driven by hcb_ctrl commands.
module hcb_dp #(
  parameter int MAX_SYMBOLS = 256,
  parameter int FREQ_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hcb_pkg::cmd_t     cmd,
  input  logic [7:0]        in_symbol,
  input  logic [31:0]       in_frequency,
  input  logic [8:0]        sym_in_use,
  input  logic              out_take,
  output hcb_pkg::dp_stat_t stat,
  output logic              out_valid,
  output logic              out_kind,
  output logic [1:0]        out_status,
  output logic [8:0]        out_nonzero,
  output logic [7:0]        out_sym,
  output logic [6:0]        out_len,
  output logic [63:0]       out_code
);
  import hcb_pkg::*;

  localparam int N   = MAX_SYMBOLS;
  localparam int SW  = (N > 2) ? $clog2(N) : 1;
  localparam int IW  = $clog2(2 * N);
  localparam int CW  = $clog2(N + 1);
  localparam int WW  = FREQ_BITS + SW;
  localparam logic [WW-1:0] W_INF = '1;

  logic [FREQ_BITS-1:0] freq_mem  [N];
  logic [WW-1:0]        live_mem  [2*N];
  logic [IW-1:0]        left_mem  [N];
  logic [IW-1:0]        right_mem [N];
  logic [DEPTH_W-1:0]   depth_mem [2*N];
  logic [CODE_W-1:0]    code_mem  [2*N];

  logic [N-1:0]         fval_r;
  logic [FREQ_BITS-1:0] fq_q_r;
  logic [WW-1:0]        lq_r;
  logic [IW-1:0]        lft_q_r, rgt_q_r;
  logic [DEPTH_W-1:0]   dq_r;
  logic [CODE_W-1:0]    cq_r;

  logic [IW-1:0] idx_r, i_r, pid_r, a_r, b_r;
  logic [WW-1:0] wa_r, wb_r;
  logic          pv_r, built_r;
  logic [CW-1:0] n_r, m_r;
  logic [SW-1:0] k_r;
  logic [7:0]    qsym_r;

  logic              sym_ok, qsym_ok;
  logic [IW:0]       scan_end;
  logic [IW-1:0]     scan_id;
  logic [IW-1:0]     inner_addr;
  logic [DEPTH_W-1:0] nd;
  logic [CODE_W-1:0] bitv;
  logic [1:0]        qstat;
  logic [CW-1:0]     n_cfg;

  assign sym_ok  = (32'(in_symbol) < N);
  assign qsym_ok = (32'(qsym_r) < N);
  assign scan_end = (IW+1)'(n_r) + (IW+1)'(k_r) - (IW+1)'(1);
  assign scan_id  = (32'(i_r) < 32'(n_r)) ? i_r
                  : IW'(N) + i_r - IW'(n_r);
  assign inner_addr = IW'(N) + IW'(k_r);
  assign n_cfg = (32'(sym_in_use) > N) ? CW'(N) : CW'(sym_in_use);

  // saturate depth at 64; branches below bit 0 set nothing
  assign nd   = (dq_r < DEPTH_W'(64)) ? dq_r + DEPTH_W'(1) : DEPTH_W'(64);
  assign bitv = (dq_r < DEPTH_W'(64)) ? (64'h8000_0000_0000_0000 >> dq_r[5:0]) : '0;

  assign qstat = !built_r ? ST_NOT_BUILT : ((m_r >= CW'(2)) ? ST_OK : ST_FEW);

  assign stat.idx_last   = (idx_r == IW'(2 * N - 1));
  assign stat.m_lt2      = (m_r < CW'(2));
  assign stat.scan_last  = ((IW+1)'(i_r) == scan_end);
  assign stat.round_last = ((CW+1)'(k_r) + (CW+1)'(2) == (CW+1)'(m_r));
  assign stat.k_zero     = (k_r == '0);
  assign stat.out_busy   = out_valid && !out_take;

  // frequency store; a symbol never loaded reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n)                       fval_r <= '0;
    else if (cmd == C_LOAD && sym_ok) fval_r[SW'(in_symbol)] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd == C_LOAD && sym_ok) freq_mem[SW'(in_symbol)] <= FREQ_BITS'(in_frequency);
    if (cmd == C_CLR_RD && 32'(idx_r) < N)
      fq_q_r <= fval_r[SW'(idx_r)] ? freq_mem[SW'(idx_r)] : '0;
  end

  // live weights
  always_ff @(posedge clk) begin
    unique case (cmd)
      C_CLR_WR: live_mem[idx_r] <= (32'(idx_r) < 32'(n_r)) ? WW'(fq_q_r) : '0;
      C_MW0:    live_mem[inner_addr] <= wa_r + wb_r;
      C_MW1:    live_mem[a_r] <= '0;
      C_MW2:    live_mem[b_r] <= '0;
      default: ;
    endcase
    if (cmd == C_SCAN) lq_r <= live_mem[scan_id];
  end

  // children
  always_ff @(posedge clk) begin
    if (cmd == C_MW0) begin
      left_mem[k_r]  <= a_r;
      right_mem[k_r] <= b_r;
    end
    if (cmd == C_WK_RD) begin
      lft_q_r <= left_mem[k_r];
      rgt_q_r <= right_mem[k_r];
    end
  end

  // depths and codes, leaves in the low half, inner nodes in the high half
  always_ff @(posedge clk) begin
    unique case (cmd)
      C_CLR_WR: begin
        depth_mem[idx_r] <= '0;
        code_mem[idx_r]  <= '0;
      end
      C_WK_L: begin
        depth_mem[lft_q_r] <= nd;
        code_mem[lft_q_r]  <= cq_r;
      end
      C_WK_R: begin
        depth_mem[rgt_q_r] <= nd;
        code_mem[rgt_q_r]  <= cq_r | bitv;
      end
      default: ;
    endcase
    if (cmd == C_WK_RD) begin
      dq_r <= depth_mem[inner_addr];
      cq_r <= code_mem[inner_addr];
    end else if (cmd == C_QRY_RD && qsym_ok) begin
      dq_r <= depth_mem[IW'(qsym_r)];
      cq_r <= code_mem[IW'(qsym_r)];
    end
  end

  // counters and scan compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      built_r <= 1'b0;
      m_r     <= '0;
      pv_r    <= 1'b0;
      idx_r   <= '0;
      i_r     <= '0;
      k_r     <= '0;
      n_r     <= '0;
    end else begin
      pv_r <= (cmd == C_SCAN);
      unique case (cmd)
        C_BINIT: begin
          idx_r   <= '0;
          m_r     <= '0;
          n_r     <= n_cfg;
          built_r <= 1'b1;
        end
        C_CLR_WR: begin
          if (32'(idx_r) < 32'(n_r) && fq_q_r != '0) m_r <= m_r + CW'(1);
          idx_r <= idx_r + IW'(1);
        end
        C_RND_INIT: begin
          i_r <= '0;
          k_r <= '0;
        end
        C_SCAN:    i_r <= i_r + IW'(1);
        C_MW2: begin
          i_r <= '0;
          k_r <= k_r + SW'(1);
        end
        C_WK_INIT: k_r <= SW'(m_r - CW'(2));
        C_WK_R:    k_r <= k_r - SW'(1);
        default: ;
      endcase
    end
  end

  // running two-smallest; lowest index wins a tie since scan runs in order
  always_ff @(posedge clk) begin
    if (cmd == C_SCAN) pid_r <= scan_id;
    if (cmd == C_RND_INIT || cmd == C_MW2) begin
      wa_r <= W_INF;
      wb_r <= W_INF;
      a_r  <= '0;
      b_r  <= '0;
    end else if (pv_r && lq_r != '0) begin
      if (lq_r < wa_r) begin
        b_r  <= a_r;
        wb_r <= wa_r;
        a_r  <= pid_r;
        wa_r <= lq_r;
      end else if (lq_r < wb_r) begin
        b_r  <= pid_r;
        wb_r <= lq_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == C_QCAP) qsym_r <= in_symbol;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd == C_OUT_B || cmd == C_OUT_Q) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == C_OUT_B) begin
      out_kind    <= KIND_BUILD;
      out_status  <= (m_r >= CW'(2)) ? ST_OK : ST_FEW;
      out_nonzero <= 9'(m_r);
      out_sym     <= '0;
      out_len     <= '0;
      out_code    <= '0;
    end else if (cmd == C_OUT_Q) begin
      out_kind    <= KIND_CODE;
      out_status  <= qstat;
      out_nonzero <= built_r ? 9'(m_r) : '0;
      out_sym     <= qsym_r;
      out_len     <= (qstat == ST_OK && qsym_ok) ? dq_r : '0;
      out_code    <= (qstat == ST_OK && qsym_ok) ? cq_r : '0;
    end
  end

endmodule

/* sv/huffman_code_builder.sv */
// Top level of the Huffman code builder: stream ports and configuration register.
// Depends on hcb_pkg, hcb_ctrl and hcb_dp.
//
// Load words store one symbol's frequency; the load word with tlast set
// starts a build over the first symbols_in_use symbols with nonzero
// frequency and returns one status word (ok, or fewer than two nonzero
// symbols). Query words return one symbol's code length and its code,
// left-aligned at bit 63. A build first clears the node stores, then for
// each of the m-1 merges scans every live node through the single read
// port of the weight memory, then walks the tree with a read, a left-child
// write and a right-child write per inner node. A query captures the
// symbol, reads its depth and code, then emits the result. The input is
// taken only between operations; a finished result waits in its register
// while the next word is accepted.
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = 256,
  parameter int FREQ_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: symbols_in_use
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // symbol[7:0], frequency[39:8]
  input  logic        in_tuser,   // op
  input  logic        in_tlast,   // last_load
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // status[1:0], nonzero_symbols[10:2],
                                  // code_symbol[18:11], code_length[25:19],
                                  // code_bits[89:26], zero pad above
  output logic        out_tuser   // kind
);
  import hcb_pkg::*;

  logic              idle, in_fire;
  cmd_t              cmd;
  dp_stat_t          stat;
  logic [8:0]        sym_in_use_r;
  logic [1:0]        o_status;
  logic [8:0]        o_nonzero;
  logic [7:0]        o_sym;
  logic [6:0]        o_len;
  logic [63:0]       o_code;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n)         sym_in_use_r <= 9'd256;
    else if (cfg_valid) sym_in_use_r <= cfg_data;
  end

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;

  hcb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_op   (in_tuser),
    .in_last (in_tlast),
    .stat    (stat),
    .idle    (idle),
    .cmd     (cmd)
  );

  hcb_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .FREQ_BITS   (FREQ_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_symbol    (in_tdata[7:0]),
    .in_frequency (in_tdata[39:8]),
    .sym_in_use   (sym_in_use_r),
    .out_take     (out_tready),
    .stat         (stat),
    .out_valid    (out_tvalid),
    .out_kind     (out_tuser),
    .out_status   (o_status),
    .out_nonzero  (o_nonzero),
    .out_sym      (o_sym),
    .out_len      (o_len),
    .out_code     (o_code)
  );

  // pack the result fields, lowest field first
  assign out_tdata = {6'd0, o_code, o_len, o_sym, o_nonzero, o_status};

endmodule
